/* rtl/mpbr_pkg.sv */
// ----------------------------------------------------------------------------
// mpbr_pkg
// Shared types, pattern tables and controller/datapath signal groups for the
// multi-pattern byte replacer.
// ----------------------------------------------------------------------------
package mpbr_pkg;

   localparam int TABLE_SIZE       = 2;
   localparam int PAT_MAX_LEN      = 15;
   localparam int LEN_BITS         = $clog2(PAT_MAX_LEN + 1);
   localparam int PAT_IDX_BITS     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int MATCH_COUNT_BITS = 16;

   typedef logic [7:0]              byte_type;
   typedef logic [LEN_BITS-1:0]     len_type;
   typedef logic [PAT_IDX_BITS-1:0] pat_idx_type;

   // search strings in test order, padded with zero bytes that are never compared
   localparam byte_type FIND_TAB [TABLE_SIZE][PAT_MAX_LEN] = '{
      '{8'h73, 8'h65, 8'h63, 8'h72, 8'h65, 8'h74, 8'h5F, 8'h75,
        8'h73, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h73, 8'h65, 8'h63, 8'h72, 8'h65, 8'h74, 8'h5F, 8'h70,
        8'h61, 8'h73, 8'h73, 8'h77, 8'h6F, 8'h72, 8'h64}
   };

   // replacement strings, same length as the search strings
   localparam byte_type REPL_TAB [TABLE_SIZE][PAT_MAX_LEN] = '{
      '{8'h6D, 8'h61, 8'h78, 8'h77, 8'h65, 8'h6C, 8'h6C, 8'h74,
        8'h72, 8'h61, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h61, 8'h63, 8'h64, 8'h65, 8'h24, 8'h32, 8'h61, 8'h32,
        8'h41, 8'h6B, 8'h23, 8'h40, 8'h21, 8'h33, 8'h33}
   };

   localparam len_type PAT_LEN [TABLE_SIZE] = '{len_type'(11), len_type'(15)};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TEST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        append;     // write incoming byte at the fill position
      logic        test;       // test one pattern at the window head
      pat_idx_type pat;        // pattern under test
      logic        load;       // move head byte to output register, shift window
      logic        last_mark;  // loaded byte ends the buffer
   } cmd_type;

   typedef struct packed {
      logic fill_almost;   // window one short of full
      logic fill_one;      // exactly one byte pending
      logic fill_nonzero;  // at least one byte pending
      logic out_free;      // output register can take a byte this cycle
   } status_type;

endpackage

/* rtl/mpbr_if.sv */
// ----------------------------------------------------------------------------
// mpbr request / response channels
// Valid-ready channels carrying input bytes and filtered result bytes.
// ----------------------------------------------------------------------------
interface mpbr_req_if;
   logic                 valid;
   logic                 ready;
   mpbr_pkg::byte_type   data_byte;
   logic                 last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mpbr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   mpbr_pkg::byte_type                     out_byte;
   logic                                   last_out;
   logic [mpbr_pkg::MATCH_COUNT_BITS-1:0]  match_count;

   modport source (output valid, output out_byte, output last_out, output match_count,
                   input ready);
   modport sink   (input valid, input out_byte, input last_out, input match_count,
                   output ready);
endinterface

/* rtl/mpbr_ctrl.sv */
// ----------------------------------------------------------------------------
// mpbr_ctrl
// Sequencer: accepts bytes, steps through the pattern tests at the window
// head and hands each finished byte to the output register.
// ----------------------------------------------------------------------------
module mpbr_ctrl #(
   parameter int NUM_PATTERNS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  mpbr_pkg::status_type stat,
   output mpbr_pkg::cmd_type    cmd
);
   import mpbr_pkg::*;

   localparam int NP_EFF = (NUM_PATTERNS < TABLE_SIZE) ? NUM_PATTERNS : TABLE_SIZE;
   localparam pat_idx_type PAT_LAST = pat_idx_type'(NP_EFF - 1);

   state_type   state_ff, state_in;
   pat_idx_type pat_ff, pat_in;
   logic        flush_ff, flush_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pat_ff   <= '0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pat_ff   <= pat_in;
         flush_ff <= flush_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      pat_in   = pat_ff;
      flush_in = flush_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               flush_in = req_last;
               pat_in   = '0;
               if (req_last || stat.fill_almost) begin
                  state_in = ST_TEST;
               end
            end
         end
         ST_TEST: begin
            if (pat_ff == PAT_LAST) begin
               state_in = ST_EMIT;
            end else begin
               pat_in = pat_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               pat_in = '0;
               if (flush_ff && !stat.fill_one) begin
                  state_in = ST_TEST;
               end else begin
                  state_in = ST_IDLE;
                  flush_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.pat       = pat_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.append = req_valid;
         end
         ST_TEST: begin
            cmd.test = 1'b1;
         end
         ST_EMIT: begin
            cmd.load      = stat.out_free;
            cmd.last_mark = stat.out_free && flush_ff && stat.fill_one;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_test_has_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST) |-> stat.fill_nonzero)
      else $error("pattern test with empty window");

   a_end_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.last_mark) |=> (state_ff == ST_IDLE && !flush_ff))
      else $error("buffer end did not return to idle");

endmodule

/* rtl/mpbr_datapath.sv */
// ----------------------------------------------------------------------------
// mpbr_datapath
// Byte window, pattern compare and rewrite at the head, match counter and
// output register.
// ----------------------------------------------------------------------------
module mpbr_datapath #(
   parameter int WINDOW_LEN = 15,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mpbr_pkg::byte_type    in_byte,
   input  mpbr_pkg::cmd_type     cmd,
   output mpbr_pkg::status_type  stat,
   input  logic                  out_ready,
   output logic                  out_valid,
   output mpbr_pkg::byte_type    out_byte,
   output logic                  out_last,
   output logic [mpbr_pkg::MATCH_COUNT_BITS-1:0] out_count
);
   import mpbr_pkg::*;

   localparam int FILL_BITS = $clog2(WINDOW_LEN + 1);
   localparam int IDX_BITS  = $clog2(WINDOW_LEN);
   localparam int CMP_LEN   = (WINDOW_LEN < PAT_MAX_LEN) ? WINDOW_LEN : PAT_MAX_LEN;
   localparam int CMP_BITS  = (FILL_BITS > LEN_BITS) ? FILL_BITS : LEN_BITS;

   byte_type                win_ff [WINDOW_LEN];
   logic [FILL_BITS-1:0]    fill_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic                    out_valid_ff;
   byte_type                out_byte_ff;
   logic                    out_last_ff;
   logic [MATCH_COUNT_BITS-1:0] out_count_ff;
   logic                    hit;
   len_type                 cur_len;

   assign stat.fill_almost  = (fill_ff == FILL_BITS'(WINDOW_LEN - 1));
   assign stat.fill_one     = (fill_ff == FILL_BITS'(1));
   assign stat.fill_nonzero = (fill_ff != '0);
   assign stat.out_free     = !out_valid_ff || out_ready;

   assign cur_len = PAT_LEN[cmd.pat];

   // pattern must fit in the pending bytes and match byte for byte
   always_comb begin
      hit = (CMP_BITS'(cur_len) <= CMP_BITS'(fill_ff));
      for (int k = 0; k < CMP_LEN; k++) begin
         if ((LEN_BITS'(k) < cur_len) && (win_ff[k] != FIND_TAB[cmd.pat][k])) begin
            hit = 1'b0;
         end
      end
   end

   // window storage
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         win_ff[fill_ff[IDX_BITS-1:0]] <= in_byte;
      end else if (cmd.test) begin
         for (int k = 0; k < CMP_LEN; k++) begin
            if (hit && (LEN_BITS'(k) < cur_len)) begin
               win_ff[k] <= REPL_TAB[cmd.pat][k];
            end
         end
      end else if (cmd.load) begin
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
      end
   end

   // fill level and match counter
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.append) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (cmd.load) begin
            fill_ff <= fill_ff - 1'b1;
         end
         if (cmd.load && cmd.last_mark) begin
            count_ff <= '0;
         end else if (cmd.test && hit && (count_ff != '1)) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_byte_ff  <= win_ff[0];
         out_last_ff  <= cmd.last_mark;
         out_count_ff <= MATCH_COUNT_BITS'(count_ff);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;
   assign out_count = out_count_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!out_valid_ff || out_ready))
      else $error("output register overwritten");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (fill_ff < FILL_BITS'(WINDOW_LEN)))
      else $error("append into full window");

   a_buffer_end_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.last_mark) |=> (count_ff == '0 && fill_ff == '0))
      else $error("window or counter not cleared at buffer end");

endmodule

/* rtl/multi_pattern_byte_replacer.sv */
// ----------------------------------------------------------------------------
// multi_pattern_byte_replacer
// Streaming fixed-string replacer: rewrites matches of the search strings in
// place and passes every byte through with a per-buffer match count.
//
//   channel   dir  payload                                 accepted when
//   req_chan  in   data_byte[7:0] last_byte                valid && ready
//   rsp_chan  out  out_byte[7:0] last_out match_count[15:0] valid && ready
//
// A byte that leaves no result is only appended to the window. A byte that
// releases a result is followed by a test of each pattern in turn at the
// window head, then a load into the output register once it is free. On the
// final byte each pending byte goes through the same tests and load.
// Synchronous reset empties the window and clears the counter. The output
// register holds while rsp_chan stalls; input is still taken while idle.
// ----------------------------------------------------------------------------
module multi_pattern_byte_replacer #(
   parameter int WINDOW_LEN   = 15,
   parameter int NUM_PATTERNS = 2,
   parameter int COUNT_BITS   = 16
) (
   input logic        clock,
   input logic        reset,
   mpbr_req_if.sink   req_chan,
   mpbr_rsp_if.source rsp_chan
);
   import mpbr_pkg::*;

   cmd_type    cmd;
   status_type stat;

   mpbr_ctrl #(
      .NUM_PATTERNS (NUM_PATTERNS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_byte),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mpbr_datapath #(
      .WINDOW_LEN (WINDOW_LEN),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (req_chan.data_byte),
      .cmd       (cmd),
      .stat      (stat),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_byte  (rsp_chan.out_byte),
      .out_last  (rsp_chan.last_out),
      .out_count (rsp_chan.match_count)
   );

endmodule

/* tb/mpbr_stream_checker.sv */
// ----------------------------------------------------------------------------
// mpbr_stream_checker
// Watches both channels of the byte replacer. It keeps its own window,
// rewrite logic and match counter, and predicts every filtered byte from the
// accepted input. Each accepted result is compared with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module mpbr_stream_checker #(
   parameter int WINDOW_LEN   = 15,
   parameter int NUM_PATTERNS = 2,
   parameter int COUNT_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   mpbr_req_if  req_mon,
   mpbr_rsp_if  rsp_mon,
   output int   errors,
   output int   pending,
   output int   checked,
   output int   replaced
);
   timeunit 1ns;
   timeprecision 1ps;
   import mpbr_pkg::*;

   localparam int TABLE_LEN = 2;
   localparam int USED_PATTERNS = (NUM_PATTERNS < TABLE_LEN) ? NUM_PATTERNS : TABLE_LEN;
   localparam longint unsigned HITS_MAX = (64'd1 << COUNT_BITS) - 1;

   localparam logic [8*11-1:0] USER_FIND = 88'h73_65_63_72_65_74_5F_75_73_65_72;
   localparam logic [8*11-1:0] USER_REPL = 88'h6D_61_78_77_65_6C_6C_74_72_61_6E;
   localparam logic [8*15-1:0] PASS_FIND = 120'h73_65_63_72_65_74_5F_70_61_73_73_77_6F_72_64;
   localparam logic [8*15-1:0] PASS_REPL = "acde$2a2Ak#@!33";

   typedef struct packed {
      byte_type    out_byte;
      logic        last_out;
      logic [15:0] match_count;
   } filtered_type;

   filtered_type    due_bytes [$];
   byte_type        win [WINDOW_LEN];
   int              fill;
   longint unsigned hits;
   int              n_err;
   int              n_checked;
   int              n_replaced;

   function automatic int pat_len(input int p);
      return (p == 0) ? 11 : 15;
   endfunction

   // byte k of a pattern, first character first
   function automatic byte_type pat_find(input int p, input int k);
      return (p == 0) ? USER_FIND[8*(10-k) +: 8] : PASS_FIND[8*(14-k) +: 8];
   endfunction

   function automatic byte_type pat_repl(input int p, input int k);
      return (p == 0) ? USER_REPL[8*(10-k) +: 8] : PASS_REPL[8*(14-k) +: 8];
   endfunction

   task automatic report(input string what);
      n_err++;
      if (n_err <= 30)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // test every pattern at one window position, rewriting in place on a hit
   task automatic rewrite_at(input int pos, input int avail);
      int len;
      bit hit;
      for (int j = 0; j < USED_PATTERNS; j++) begin
         len = pat_len(j);
         if (pos >= avail || len > avail - pos || pos + len > WINDOW_LEN)
            continue;
         hit = 1'b1;
         for (int k = 0; k < len; k++)
            if (win[pos+k] != pat_find(j, k))
               hit = 1'b0;
         if (hit) begin
            for (int k = 0; k < len; k++)
               win[pos+k] = pat_repl(j, k);
            if (hits < HITS_MAX)
               hits++;
            n_replaced++;
         end
      end
   endtask

   task automatic queue_result(input byte_type b, input logic last);
      filtered_type item;
      item.out_byte    = b;
      item.last_out    = last;
      item.match_count = hits[15:0];
      due_bytes.push_back(item);
   endtask

   task automatic take_byte(input byte_type b, input logic last);
      if (fill < WINDOW_LEN) begin
         win[fill] = b;
         fill++;
      end
      if (!last) begin
         if (fill >= WINDOW_LEN) begin
            rewrite_at(0, fill);
            queue_result(win[0], 1'b0);
            for (int i = 0; i < WINDOW_LEN - 1; i++)
               win[i] = win[i+1];
            fill = WINDOW_LEN - 1;
         end
      end else begin
         // flush: test and release every pending byte, oldest first
         for (int pos = 0; pos < fill; pos++) begin
            rewrite_at(pos, fill);
            queue_result(win[pos], (pos + 1 == fill));
         end
         fill = 0;
         hits = 0;
      end
   endtask

   always @(posedge clock) begin
      filtered_type want;
      if (reset) begin
         fill = 0;
         hits = 0;
         due_bytes.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (due_bytes.size() == 0) begin
               report($sformatf("result byte %02h arrived with nothing outstanding",
                                rsp_mon.out_byte));
            end else begin
               want = due_bytes.pop_front();
               n_checked++;
               if (rsp_mon.out_byte !== want.out_byte)
                  report($sformatf("out_byte %02h, expected %02h",
                                   rsp_mon.out_byte, want.out_byte));
               if (rsp_mon.last_out !== want.last_out)
                  report($sformatf("last_out %b, expected %b (byte %02h)",
                                   rsp_mon.last_out, want.last_out, want.out_byte));
               if (rsp_mon.match_count !== want.match_count)
                  report($sformatf("match_count %0d, expected %0d (byte %02h)",
                                   rsp_mon.match_count, want.match_count, want.out_byte));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            take_byte(req_mon.data_byte, req_mon.last_byte);
      end
      errors   <= n_err;
      pending  <= due_bytes.size();
      checked  <= n_checked;
      replaced <= n_replaced;
   end

endmodule

/* tb/multi_pattern_byte_replacer_tb.sv */
// ----------------------------------------------------------------------------
// multi_pattern_byte_replacer_tb
// Drives buffers of bytes into the replacer with random gaps and random
// result stalls. A directed opening covers single-byte buffers at the byte
// extremes and each pattern as a whole buffer; random buffers then mix whole,
// partial, corrupted and overlapping patterns with noise. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module multi_pattern_byte_replacer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mpbr_pkg::*;

   localparam int ITEM_GOAL = 480;
   localparam logic [8*11-1:0] USER_WORD = 88'h73_65_63_72_65_74_5F_75_73_65_72;
   localparam logic [8*15-1:0] PASS_WORD = 120'h73_65_63_72_65_74_5F_70_61_73_73_77_6F_72_64;

   logic     clock;
   logic     reset;
   bit       steady;      // no idling on either side while set
   byte_type buffer_q [$];
   int       n_buffers;
   int       n_bytes;
   int       random_bytes;
   int       errors;
   int       pending;
   int       checked;
   int       replaced;

   mpbr_req_if req_chan ();
   mpbr_rsp_if rsp_chan ();

   multi_pattern_byte_replacer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mpbr_stream_checker stream_check (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_chan),
      .rsp_mon  (rsp_chan),
      .errors   (errors),
      .pending  (pending),
      .checked  (checked),
      .replaced (replaced)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("multi_pattern_byte_replacer_tb: errors");
      $finish;
   end

   function automatic int word_len(input int p);
      return (p == 0) ? 11 : 15;
   endfunction

   function automatic byte_type word_byte(input int p, input int k);
      return (p == 0) ? USER_WORD[8*(10-k) +: 8] : PASS_WORD[8*(14-k) +: 8];
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic push_word(input int p, input int n);
      for (int k = 0; k < n; k++)
         buffer_q.push_back(word_byte(p, k));
   endtask

   // random byte, or a pattern character to provoke near misses
   task automatic push_noise();
      int p;
      p = $urandom_range(0, 1);
      if ($urandom_range(0, 1))
         buffer_q.push_back(byte_type'($urandom_range(0, 255)));
      else
         buffer_q.push_back(word_byte(p, $urandom_range(0, word_len(p) - 1)));
   endtask

   task automatic build_random_buffer();
      int target;
      int r;
      int p;
      r = $urandom_range(0, 99);
      if (r < 70)
         target = $urandom_range(1, 30);
      else if (r < 95)
         target = $urandom_range(31, 60);
      else
         target = $urandom_range(61, 120);
      while (buffer_q.size() < target) begin
         r = $urandom_range(0, 99);
         p = $urandom_range(0, 1);
         if (r < 30) begin
            push_word(p, word_len(p));
         end else if (r < 45) begin
            push_word(p, $urandom_range(1, word_len(p) - 1));
         end else if (r < 55) begin
            push_word(p, word_len(p));
            buffer_q[buffer_q.size() - 1 - $urandom_range(0, word_len(p) - 1)] =
               byte_type'($urandom_range(0, 255));
         end else begin
            repeat ($urandom_range(1, 4)) push_noise();
         end
      end
      // cut a pattern short at the end of the buffer now and then
      if ($urandom_range(0, 3) == 0) begin
         p = $urandom_range(0, 1);
         push_word(p, $urandom_range(1, word_len(p) - 1));
      end
   endtask

   // hand the buffer over one transaction at a time, last flag on the final byte
   task automatic send_buffer();
      int gap;
      for (int i = 0; i < buffer_q.size(); i++) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_chan.valid     <= 1'b1;
         req_chan.data_byte <= buffer_q[i];
         req_chan.last_byte <= (i == buffer_q.size() - 1);
         do @(posedge clock); while (req_chan.ready !== 1'b1);
      end
      n_buffers++;
      n_bytes += buffer_q.size();
      buffer_q.delete();
   endtask

   // result side: stall at random, hold ready low through reset
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.last_byte <= 1'b0;
      steady = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single-byte buffers at both byte extremes
      buffer_q.push_back(8'h00);
      send_buffer();
      buffer_q.push_back(8'hFF);
      send_buffer();
      // each pattern filling a whole buffer, ending exactly on the last byte
      push_word(0, 11);
      send_buffer();
      push_word(1, 15);
      send_buffer();

      while (random_bytes < ITEM_GOAL) begin
         steady = ($urandom_range(0, 5) == 0);
         build_random_buffer();
         random_bytes += buffer_q.size();
         send_buffer();
      end
      req_chan.valid <= 1'b0;
      steady = 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d buffers, %0d bytes in (%0d random)",
               n_buffers, n_bytes, random_bytes);
      $display("Compared %0d filtered bytes, %0d pattern rewrites expected",
               checked, replaced);
      if (errors == 0) begin
         $display("multi_pattern_byte_replacer_tb: clean");
      end else begin
         $display("multi_pattern_byte_replacer_tb: errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/mpbr_pkg.sv
rtl/mpbr_if.sv
rtl/mpbr_ctrl.sv
rtl/mpbr_datapath.sv
rtl/multi_pattern_byte_replacer.sv
tb/mpbr_stream_checker.sv
tb/multi_pattern_byte_replacer_tb.sv
